FILE: rtl/core/sbrc_pkg.sv
package sbrc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int CFG_IDX_BITS   = 3;

	localparam int CLIP_LEFT_RST   = 0;
	localparam int CLIP_TOP_RST    = 0;
	localparam int CLIP_WIDTH_RST  = 320;
	localparam int CLIP_HEIGHT_RST = 240;
	localparam int WRAP_SPAN_RST   = 320;
	localparam int SHAKE_X_RST     = 0;
	localparam int SHAKE_Y_RST     = 0;

	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_SPAN   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHAKE_X     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHAKE_Y     = 3'd6;

	localparam logic [1:0] EDGE_TOP    = 2'd0;
	localparam logic [1:0] EDGE_RIGHT  = 2'd1;
	localparam logic [1:0] EDGE_BOTTOM = 2'd2;
	localparam logic [1:0] EDGE_LEFT   = 2'd3;

endpackage

FILE: rtl/core/sprite_blit_rect_clipper_core.sv
// Sprite blit rectangle clipper. A request is taken when start is high and busy is low;
// it yields zero, one or two draw commands, each shown for exactly one cycle with
// out_strobe high, and last marks the final command of the request. The receiver cannot
// stall the block. The first command passes through the input, clip and result registers and
// a wrapped second command follows in the next cycle. A new request can be taken while
// earlier ones are in flight unless busy is high; one with wrap_enable set whose destination
// starts left of the clip area or reaches its right side keeps busy high for the cycle after
// it is taken, because both commands leave through the one result register. Configuration
// writes are always ready and must only be made while no request is in flight.
module sprite_blit_rect_clipper_core #(
	parameter int COORD_BITS = sbrc_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_BITS-1:0]      dest_x,
	input  logic signed [COORD_BITS-1:0]      dest_y,
	input  logic signed [COORD_BITS-1:0]      source_x,
	input  logic signed [COORD_BITS-1:0]      source_y,
	input  logic        [COORD_BITS-2:0]      width,
	input  logic        [COORD_BITS-2:0]      height,
	input  logic                              wrap_enable,
	input  logic                              edge_enable,
	input  logic        [1:0]                 edge_select,
	input  logic signed [COORD_BITS-1:0]      edge_threshold,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic        [COORD_BITS-1:0]      cfg_data,
	output logic                              out_strobe,
	output logic signed [COORD_BITS:0]        out_src_x,
	output logic signed [COORD_BITS:0]        out_src_y,
	output logic signed [COORD_BITS:0]        out_src_w,
	output logic signed [COORD_BITS:0]        out_src_h,
	output logic signed [COORD_BITS:0]        out_dst_x,
	output logic signed [COORD_BITS:0]        out_dst_y,
	output logic signed [COORD_BITS:0]        out_dst_w,
	output logic signed [COORD_BITS:0]        out_dst_h,
	output logic                              last
);

	import sbrc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int SW = COORD_BITS - 1;
	localparam int OW = COORD_BITS + 1;
	localparam int W  = COORD_BITS + 4;

	localparam logic signed [W-1:0] OUT_MAX = {{(W-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [W-1:0] OUT_MIN = ~OUT_MAX;

	typedef logic signed [W-1:0] wide_t;

	typedef struct packed {
		wide_t sx;
		wide_t sy;
		wide_t sw;
		wide_t sh;
		wide_t dx;
		wide_t dy;
		wide_t dw;
		wide_t dh;
	} rect_t;

	typedef struct packed {
		logic  hid;
		rect_t r;
	} trim_t;

	function automatic wide_t sext(logic [C-1:0] v);
		return {{(W-C){v[C-1]}}, v};
	endfunction

	function automatic wide_t zext(logic [SW-1:0] v);
		return {{(W-SW){1'b0}}, v};
	endfunction

	function automatic logic signed [OW-1:0] sat(wide_t v);
		wide_t s;
		s = v;
		if (v > OUT_MAX)
			s = OUT_MAX;
		else if (v < OUT_MIN)
			s = OUT_MIN;
		return s[OW-1:0];
	endfunction

	function automatic rect_t clip_rect(rect_t r, wide_t cx, wide_t cy, wide_t cr, wide_t cb);
		rect_t o;
		wide_t d;
		o = r;
		if (r.dx >= cr || r.dx + r.dw < cx || r.dy >= cb || r.dy + r.dh < cy) begin
			o.sw = '0;
			o.sh = '0;
		end else begin
			if (r.dx < cx) begin
				d    = cx - r.dx;
				o.sx = r.sx + d;
				o.sw = r.sw - d;
				o.dx = cx;
			end
			if (o.dx + o.dw >= cr)
				o.sw = o.sw - (o.dx + o.dw - cr);
			if (r.dy < cy) begin
				d    = cy - r.dy;
				o.sy = r.sy + d;
				o.sh = r.sh - d;
				o.dy = cy;
			end
			if (o.dy + o.dh >= cb)
				o.sh = o.sh - (o.dy + o.dh - cb);
		end
		return o;
	endfunction

	function automatic trim_t trim_rect(rect_t r, logic [1:0] edge_sel, wide_t t,
			wide_t shx, wide_t shy);
		trim_t o;
		wide_t d;
		o.hid = 1'b0;
		o.r   = r;
		unique case (edge_sel)
			EDGE_TOP: begin
				if (t >= r.dy) begin
					if (r.dy + r.dh <= t) begin
						o.hid = 1'b1;
					end else begin
						d      = t - r.dy;
						o.r.sy = r.sy + d;
						o.r.sh = r.sh - d;
						o.r.dy = t + shy;
						o.r.dh = r.sh - d;
					end
				end
			end
			EDGE_RIGHT: begin
				if (r.dx + r.sw >= t) begin
					if (t <= r.dx) begin
						o.hid = 1'b1;
					end else begin
						o.r.sw = t - r.dx;
						o.r.dw = t - r.dx;
					end
				end
			end
			EDGE_BOTTOM: begin
				if (r.dy + r.sh >= t) begin
					if (t <= r.dy) begin
						o.hid = 1'b1;
					end else begin
						o.r.sh = t - r.dy;
						o.r.dh = t - r.dy;
					end
				end
			end
			EDGE_LEFT: begin
				if (t >= r.dx) begin
					if (r.dx + r.sw <= t) begin
						o.hid = 1'b1;
					end else begin
						d      = t - r.dx;
						o.r.sx = r.sx + d;
						o.r.sw = r.sw - d;
						o.r.dx = t + shx;
						o.r.dw = r.sw - d;
					end
				end
			end
			default: begin
				o.hid = 1'b0;
			end
		endcase
		return o;
	endfunction

	// configuration registers
	logic signed [C-1:0]  clip_left_q;
	logic signed [C-1:0]  clip_top_q;
	logic        [SW-1:0] clip_width_q;
	logic        [SW-1:0] clip_height_q;
	logic        [SW-1:0] wrap_span_q;
	logic signed [C-1:0]  shake_x_q;
	logic signed [C-1:0]  shake_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= C'(CLIP_LEFT_RST);
			clip_top_q    <= C'(CLIP_TOP_RST);
			clip_width_q  <= SW'(CLIP_WIDTH_RST);
			clip_height_q <= SW'(CLIP_HEIGHT_RST);
			wrap_span_q   <= SW'(WRAP_SPAN_RST);
			shake_x_q     <= C'(SHAKE_X_RST);
			shake_y_q     <= C'(SHAKE_Y_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:   clip_left_q   <= cfg_data;
				REG_CLIP_TOP:    clip_top_q    <= cfg_data;
				REG_CLIP_WIDTH:  clip_width_q  <= cfg_data[SW-1:0];
				REG_CLIP_HEIGHT: clip_height_q <= cfg_data[SW-1:0];
				REG_WRAP_SPAN:   wrap_span_q   <= cfg_data[SW-1:0];
				REG_SHAKE_X:     shake_x_q     <= cfg_data;
				REG_SHAKE_Y:     shake_y_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	wide_t cx_w, cy_w, cr_w, cb_w, span_w, shx_w, shy_w;

	assign cx_w   = sext(clip_left_q);
	assign cy_w   = sext(clip_top_q);
	assign cr_w   = cx_w + zext(clip_width_q);
	assign cb_w   = cy_w + zext(clip_height_q);
	assign span_w = zext(wrap_span_q);
	assign shx_w  = sext(shake_x_q);
	assign shy_w  = sext(shake_y_q);

	// input stage
	logic accept;
	logic wrap_left, wrap_right, two_maybe;
	logic busy_q;

	assign accept     = start && !busy_q;
	assign busy       = busy_q;
	assign wrap_left  = sext(dest_x) < cx_w;
	assign wrap_right = sext(dest_x) + zext(width) >= cr_w;
	assign two_maybe  = wrap_enable && (wrap_left || wrap_right);

	logic                valid_s1;
	logic signed [C-1:0] dx_s1, dy_s1, sx_s1, sy_s1, thr_s1;
	logic       [SW-1:0] w_s1, h_s1;
	logic                side_s1, left_s1, trim_s1;
	logic        [1:0]   edge_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= accept && two_maybe;
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_s1   <= dest_x;
			dy_s1   <= dest_y;
			sx_s1   <= source_x;
			sy_s1   <= source_y;
			w_s1    <= width;
			h_s1    <= height;
			side_s1 <= two_maybe;
			left_s1 <= wrap_left;
			trim_s1 <= edge_enable;
			edge_s1 <= edge_select;
			thr_s1  <= edge_threshold;
		end
	end

	// clip stage
	rect_t first_raw, second_raw;

	always_comb begin
		first_raw.sx = sext(sx_s1);
		first_raw.sy = sext(sy_s1);
		first_raw.sw = zext(w_s1);
		first_raw.sh = zext(h_s1);
		first_raw.dx = sext(dx_s1);
		first_raw.dy = sext(dy_s1);
		first_raw.dw = zext(w_s1);
		first_raw.dh = zext(h_s1);
		second_raw    = first_raw;
		second_raw.dx = left_s1 ? sext(dx_s1) + span_w : sext(dx_s1) - span_w;
	end

	logic        valid_s2, side_s2, trim_s2;
	logic [1:0]  edge_s2;
	wide_t       thr_s2;
	rect_t       first_s2, second_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			first_s2  <= clip_rect(first_raw, cx_w, cy_w, cr_w, cb_w);
			second_s2 <= clip_rect(second_raw, cx_w, cy_w, cr_w, cb_w);
			side_s2   <= side_s1;
			trim_s2   <= trim_s1;
			edge_s2   <= edge_s1;
			thr_s2    <= sext(thr_s1);
		end
	end

	// trim and result stage
	trim_t first_t, second_t;
	rect_t first_fin, second_fin;
	logic  first_hid, second_ok;

	always_comb begin
		first_t    = trim_rect(first_s2, edge_s2, thr_s2, shx_w, shy_w);
		second_t   = trim_rect(second_s2, edge_s2, thr_s2, shx_w, shy_w);
		first_fin  = trim_s2 ? first_t.r : first_s2;
		second_fin = trim_s2 ? second_t.r : second_s2;
		first_hid  = trim_s2 && first_t.hid;
		second_ok  = side_s2 && !(trim_s2 && second_t.hid);
	end

	logic  strobe_q, last_q, pend_valid_q;
	rect_t out_q, pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (valid_s2 && !first_hid) begin
			strobe_q     <= 1'b1;
			pend_valid_q <= second_ok;
		end else begin
			strobe_q     <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !first_hid) begin
			out_q  <= first_fin;
			last_q <= !second_ok;
			pend_q <= second_fin;
		end else if (pend_valid_q) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign out_strobe = strobe_q;
	assign last       = last_q;
	assign out_src_x  = sat(out_q.sx);
	assign out_src_y  = sat(out_q.sy);
	assign out_src_w  = sat(out_q.sw);
	assign out_src_h  = sat(out_q.sh);
	assign out_dst_x  = sat(out_q.dx);
	assign out_dst_y  = sat(out_q.dy);
	assign out_dst_w  = sat(out_q.dw);
	assign out_dst_h  = sat(out_q.dh);

endmodule

FILE: tb/tb_top.sv
module tb_top;
	import sbrc_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic signed [CB-1:0] dest_x;
		logic signed [CB-1:0] dest_y;
		logic signed [CB-1:0] source_x;
		logic signed [CB-1:0] source_y;
		logic [CB-2:0] width;
		logic [CB-2:0] height;
		logic wrap_enable;
		logic edge_enable;
		logic [1:0] edge_select;
		logic signed [CB-1:0] edge_threshold;
	} blit_req_t;

	typedef struct {
		longint sx, sy, sw, sh, dx, dy, dw, dh;
	} rect_t;

	// element 8 holds last, elements 0..7 src x y w h, dst x y w h
	typedef logic [8:0][CB:0] blit_cmd_t;

	class blit_scoreboard;
		longint clip_left, clip_top, clip_width, clip_height, wrap_span, shake_x, shake_y;
		blit_cmd_t draw_q[$];
		int errors;

		function new();
			clip_left = CLIP_LEFT_RST;
			clip_top = CLIP_TOP_RST;
			clip_width = CLIP_WIDTH_RST;
			clip_height = CLIP_HEIGHT_RST;
			wrap_span = WRAP_SPAN_RST;
			shake_x = SHAKE_X_RST;
			shake_y = SHAKE_Y_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] data);
			case (idx)
				REG_CLIP_LEFT: clip_left = longint'(signed'(data));
				REG_CLIP_TOP: clip_top = longint'(signed'(data));
				REG_CLIP_WIDTH: clip_width = longint'(data[CB-2:0]);
				REG_CLIP_HEIGHT: clip_height = longint'(data[CB-2:0]);
				REG_WRAP_SPAN: wrap_span = longint'(data[CB-2:0]);
				REG_SHAKE_X: shake_x = longint'(signed'(data));
				REG_SHAKE_Y: shake_y = longint'(signed'(data));
				default: ;
			endcase
		endfunction

		function logic [CB:0] sat(longint v);
			longint hi;
			hi = (longint'(1) << CB) - 1;
			if (v > hi)
				v = hi;
			if (v < -hi - 1)
				v = -hi - 1;
			return v[CB:0];
		endfunction

		function rect_t make_rect(longint sx, longint sy, longint w, longint h,
				longint dx, longint dy);
			rect_t r;
			r.sx = sx; r.sy = sy; r.sw = w; r.sh = h;
			r.dx = dx; r.dy = dy; r.dw = w; r.dh = h;
			return r;
		endfunction

		function rect_t clip_rect(rect_t r);
			longint d;
			if (r.dx >= clip_left + clip_width || r.dx + r.dw < clip_left ||
			    r.dy >= clip_top + clip_height || r.dy + r.dh < clip_top) begin
				r.sw = 0;
				r.sh = 0;
				return r;
			end
			// left clip keeps dw as it was
			if (r.dx < clip_left) begin
				d = clip_left - r.dx;
				r.sx += d;
				r.sw -= d;
				r.dx = clip_left;
			end
			if (r.dx + r.dw >= clip_left + clip_width)
				r.sw -= r.dx + r.dw - clip_left - clip_width;
			if (r.dy < clip_top) begin
				d = clip_top - r.dy;
				r.sy += d;
				r.sh -= d;
				r.dy = clip_top;
			end
			if (r.dy + r.dh >= clip_top + clip_height)
				r.sh -= r.dy + r.dh - clip_top - clip_height;
			return r;
		endfunction

		// returns 1 when the edge hides the whole sprite
		function bit trim_rect(inout rect_t r, input logic [1:0] sel, input longint t);
			longint d;
			case (sel)
				EDGE_TOP: begin
					if (t < r.dy)
						return 0;
					if (r.dy + r.dh <= t)
						return 1;
					d = t - r.dy;
					r.sy += d;
					r.sh -= d;
					r.dy = t + shake_y;
					r.dh = r.sh;
				end
				EDGE_RIGHT: begin
					if (r.dx + r.sw < t)
						return 0;
					if (t <= r.dx)
						return 1;
					r.sw = t - r.dx;
					r.dw = r.sw;
				end
				EDGE_BOTTOM: begin
					if (r.dy + r.sh < t)
						return 0;
					if (t <= r.dy)
						return 1;
					r.sh = t - r.dy;
					r.dh = r.sh;
				end
				default: begin
					if (t < r.dx)
						return 0;
					if (r.dx + r.sw <= t)
						return 1;
					d = t - r.dx;
					r.sx += d;
					r.sw -= d;
					r.dx = t + shake_x;
					r.dw = r.sw;
				end
			endcase
			return 0;
		endfunction

		function void push_cmd(rect_t r, bit is_last);
			blit_cmd_t c;
			c[0] = sat(r.sx);
			c[1] = sat(r.sy);
			c[2] = sat(r.sw);
			c[3] = sat(r.sh);
			c[4] = sat(r.dx);
			c[5] = sat(r.dy);
			c[6] = sat(r.dw);
			c[7] = sat(r.dh);
			c[8] = {{CB{1'b0}}, is_last};
			draw_q.push_back(c);
		endfunction

		function void note_request(blit_req_t q);
			rect_t first, second;
			longint dx, dy, sx, sy, w, h, thr, wx;
			bit side;
			dx = q.dest_x;
			dy = q.dest_y;
			sx = q.source_x;
			sy = q.source_y;
			w = q.width;
			h = q.height;
			thr = q.edge_threshold;
			side = 0;
			wx = 0;
			first = clip_rect(make_rect(sx, sy, w, h, dx, dy));
			if (q.edge_enable) begin
				if (trim_rect(first, q.edge_select, thr))
					return;
			end
			if (q.wrap_enable) begin
				if (dx < clip_left) begin
					wx = dx + wrap_span;
					side = 1;
				end else if (dx + w >= clip_left + clip_width) begin
					wx = dx - wrap_span;
					side = 1;
				end
			end
			if (side) begin
				second = clip_rect(make_rect(sx, sy, w, h, wx, dy));
				if (q.edge_enable) begin
					if (trim_rect(second, q.edge_select, thr))
						side = 0;
				end
			end
			push_cmd(first, !side);
			if (side)
				push_cmd(second, 1);
		endfunction

		function string field_name(int i);
			case (i)
				0: return "out_src_x";
				1: return "out_src_y";
				2: return "out_src_w";
				3: return "out_src_h";
				4: return "out_dst_x";
				5: return "out_dst_y";
				6: return "out_dst_w";
				7: return "out_dst_h";
				default: return "last";
			endcase
		endfunction

		function void check_cmd(blit_cmd_t act);
			blit_cmd_t exp;
			if (draw_q.size() == 0) begin
				$display("%0t: draw command with none expected, src_x %0d dst_x %0d",
					$time, $signed(act[0]), $signed(act[4]));
				errors++;
				return;
			end
			exp = draw_q.pop_front();
			for (int i = 0; i < 9; i++) begin
				if (exp[i] !== act[i]) begin
					$display("%0t: %s expected %0d actual %0d", $time, field_name(i),
						$signed(exp[i]), $signed(act[i]));
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [CB-1:0] dest_x, dest_y, source_x, source_y, edge_threshold;
	logic [CB-2:0] width, height;
	logic wrap_enable, edge_enable;
	logic [1:0] edge_select;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CB-1:0] cfg_data;
	logic out_strobe;
	logic signed [CB:0] out_src_x, out_src_y, out_src_w, out_src_h;
	logic signed [CB:0] out_dst_x, out_dst_y, out_dst_w, out_dst_h;
	logic last;

	blit_scoreboard sb;
	int cycles;

	sprite_blit_rect_clipper_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.source_x(source_x),
		.source_y(source_y),
		.width(width),
		.height(height),
		.wrap_enable(wrap_enable),
		.edge_enable(edge_enable),
		.edge_select(edge_select),
		.edge_threshold(edge_threshold),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_strobe(out_strobe),
		.out_src_x(out_src_x),
		.out_src_y(out_src_y),
		.out_src_w(out_src_w),
		.out_src_h(out_src_h),
		.out_dst_x(out_dst_x),
		.out_dst_y(out_dst_y),
		.out_dst_w(out_dst_w),
		.out_dst_h(out_dst_h),
		.last(last)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_strobe)
			sb.check_cmd({{CB{1'b0}}, last, out_dst_h, out_dst_w, out_dst_y, out_dst_x,
				out_src_h, out_src_w, out_src_y, out_src_x});
	end

	function automatic blit_req_t mk_req(int dx, int dy, int sx, int sy, int w, int h,
			bit wrap, bit trim, logic [1:0] sel, int thr);
		blit_req_t q;
		q.dest_x = dx[CB-1:0];
		q.dest_y = dy[CB-1:0];
		q.source_x = sx[CB-1:0];
		q.source_y = sy[CB-1:0];
		q.width = w[CB-2:0];
		q.height = h[CB-2:0];
		q.wrap_enable = wrap;
		q.edge_enable = trim;
		q.edge_select = sel;
		q.edge_threshold = thr[CB-1:0];
		return q;
	endfunction

	function automatic blit_req_t rand_req();
		blit_req_t q;
		longint w, h, x, y, r, base, span, t;
		if ($urandom_range(0, 4) == 0) begin
			// unconstrained noise
			q.dest_x = CB'($urandom);
			q.dest_y = CB'($urandom);
			q.source_x = CB'($urandom);
			q.source_y = CB'($urandom);
			q.width = (CB-1)'($urandom);
			q.height = (CB-1)'($urandom);
			q.wrap_enable = 1'($urandom_range(0, 1));
			q.edge_enable = 1'($urandom_range(0, 1));
			q.edge_select = 2'($urandom_range(0, 3));
			q.edge_threshold = CB'($urandom);
			return q;
		end
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200);
		h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200);
		r = $urandom_range(0, int'(sb.clip_width + w + 100));
		x = sb.clip_left + r - w - 50;
		r = $urandom_range(0, int'(sb.clip_height + h + 100));
		y = sb.clip_top + r - h - 50;
		q.dest_x = x[CB-1:0];
		q.dest_y = y[CB-1:0];
		q.source_x = CB'($urandom);
		q.source_y = CB'($urandom);
		q.width = w[CB-2:0];
		q.height = h[CB-2:0];
		q.wrap_enable = ($urandom_range(0, 2) != 0);
		q.edge_enable = ($urandom_range(0, 2) != 0);
		q.edge_select = 2'($urandom_range(0, 3));
		if (q.edge_select == EDGE_TOP || q.edge_select == EDGE_BOTTOM) begin
			base = y;
			span = h;
		end else begin
			base = x;
			span = w;
		end
		r = $urandom_range(0, int'(span + 40));
		t = base + r - 20;
		q.edge_threshold = t[CB-1:0];
		return q;
	endfunction

	task automatic send_req(blit_req_t q);
		start <= 1'b1;
		dest_x <= q.dest_x;
		dest_y <= q.dest_y;
		source_x <= q.source_x;
		source_y <= q.source_y;
		width <= q.width;
		height <= q.height;
		wrap_enable <= q.wrap_enable;
		edge_enable <= q.edge_enable;
		edge_select <= q.edge_select;
		edge_threshold <= q.edge_threshold;
		do @(posedge clk); while (busy);
		sb.note_request(q);
	endtask

	task automatic send_item(blit_req_t q, bit quiet);
		send_req(q);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.draw_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		if ($urandom_range(0, 3) == 0) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic program_regs(logic [CB-1:0] cl, logic [CB-1:0] ct, logic [CB-1:0] cw,
			logic [CB-1:0] ch, logic [CB-1:0] sp, logic [CB-1:0] shx, logic [CB-1:0] shy);
		put_reg(REG_CLIP_LEFT, cl);
		put_reg(REG_CLIP_TOP, ct);
		put_reg(REG_CLIP_WIDTH, cw);
		put_reg(REG_CLIP_HEIGHT, ch);
		put_reg(REG_WRAP_SPAN, sp);
		put_reg(REG_SHAKE_X, shx);
		put_reg(REG_SHAKE_Y, shy);
		// out of range index must not disturb anything
		put_reg(REG_UNUSED, CB'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_regs();
		int cl, ct, cw, ch, sp;
		cl = $urandom_range(0, 600);
		cl = cl - 300;
		ct = $urandom_range(0, 600);
		ct = ct - 300;
		cw = $urandom_range(16, 400);
		ch = $urandom_range(16, 300);
		sp = ($urandom_range(0, 1) == 1) ? cw : $urandom_range(0, 32767);
		program_regs(CB'(cl), CB'(ct), CB'(cw | ($urandom_range(0, 1) << (CB - 1))),
			CB'(ch), CB'(sp), CB'($urandom), CB'($urandom));
	endtask

	task automatic run_phase(int n, bit quiet, int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain();
			send_item(rand_req(), quiet);
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		dest_x = '0;
		dest_y = '0;
		source_x = '0;
		source_y = '0;
		width = '0;
		height = '0;
		wrap_enable = 1'b0;
		edge_enable = 1'b0;
		edge_select = EDGE_TOP;
		edge_threshold = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CLIP_LEFT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items against the reset clip area
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(400, 20, 5, 6, 32, 16, 0, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(-32768, -32768, -32768, -32768, 0, 0, 1, 1, EDGE_LEFT, -32768), 0);
		send_item(mk_req(32767, 32767, 32767, 32767, 32767, 32767, 1, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(-10, 20, 3, 4, 32, 16, 0, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(300, 20, 3, 4, 32, 16, 0, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(10, -8, 3, 4, 32, 16, 0, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(10, 230, 3, 4, 32, 16, 0, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_TOP, 25), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_TOP, 40), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_TOP, 5), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_RIGHT, 30), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_RIGHT, 5), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_BOTTOM, 30), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_BOTTOM, 10), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_LEFT, 20), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_LEFT, 50), 0);
		send_item(mk_req(-10, 20, 0, 0, 32, 16, 1, 0, EDGE_TOP, 0), 0);
		send_item(mk_req(300, 20, 0, 0, 32, 16, 1, 0, EDGE_TOP, 0), 0);
		// wrapped copy hidden, first kept
		send_item(mk_req(300, 20, 0, 0, 32, 16, 1, 1, EDGE_LEFT, 310), 0);
		// first hidden, no wrapped copy either
		send_item(mk_req(300, 20, 0, 0, 32, 16, 1, 1, EDGE_LEFT, 32767), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_BOTTOM, -32768), 0);
		send_item(mk_req(10, 20, 0, 0, 32, 16, 0, 1, EDGE_TOP, 32767), 0);
		send_item(mk_req(10, 20, 0, 0, 0, 0, 1, 0, EDGE_TOP, 0), 0);
		drain();

		program_regs(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		run_phase(96, 0, -1);
		program_regs(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
		run_phase(96, 0, -1);
		program_regs(16'd0, 16'd0, 16'd320, 16'd240, 16'd320, 16'd7, -16'sd5);
		run_phase(96, 0, 48);
		random_regs();
		run_phase(96, 0, -1);
		random_regs();
		run_phase(96, 0, -1);
		random_regs();
		run_phase(96, 1, -1);

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/sbrc_pkg.sv
rtl/core/sprite_blit_rect_clipper_core.sv
tb/tb_top.sv
